/* rtl/mwce_pkg.sv */
// Package for the melt wipe column engine: shared types, configuration and
// action codes, the microcode program of the sequencer and small helpers.
// No dependencies.
package mwce_pkg;

  typedef logic [1:0]  action_t;
  typedef logic [0:0]  cfg_idx_t;
  typedef logic [12:0] dim_t;
  typedef logic [3:0]  pc_t;
  typedef logic [3:0]  op_t;
  typedef logic [2:0]  cond_t;

  localparam int SX_W  = 12;
  localparam int RND_W = 8;
  localparam int DIM_W = 13;
  localparam int OFS_W = 9;

  localparam dim_t WIDTH_RESET  = 13'd320;
  localparam dim_t HEIGHT_RESET = 13'd200;

  localparam cfg_idx_t CFG_SCREEN_WIDTH  = 1'd0;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 1'd1;

  localparam action_t ACT_SEED  = 2'd0;
  localparam action_t ACT_TICK  = 2'd1;
  localparam action_t ACT_QUERY = 2'd2;

  // Datapath operations, one per control word.
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_ACCEPT     = 4'd1;
  localparam op_t OP_SEED_RD    = 4'd2;
  localparam op_t OP_SEED_WR    = 4'd3;
  localparam op_t OP_DIV_WORM   = 4'd4;
  localparam op_t OP_Q_RD       = 4'd5;
  localparam op_t OP_DIV_ROW    = 4'd6;
  localparam op_t OP_Q_LATCH    = 4'd7;
  localparam op_t OP_TICK_START = 4'd8;
  localparam op_t OP_TICK_STEP  = 4'd9;
  localparam op_t OP_RESULT     = 4'd10;

  // Jump conditions.
  localparam cond_t C_ALWAYS    = 3'd0;
  localparam cond_t C_DISPATCH  = 3'd1;
  localparam cond_t C_SEED_SKIP = 3'd2;
  localparam cond_t C_DIV_DONE  = 3'd3;
  localparam cond_t C_PTR_LAST  = 3'd4;
  localparam cond_t C_OUT_FREE  = 3'd5;

  // Program steps.
  localparam pc_t S_IDLE       = 4'd0;
  localparam pc_t S_SEED_RD    = 4'd1;
  localparam pc_t S_SEED_WR    = 4'd2;
  localparam pc_t S_Q_DIV1     = 4'd3;
  localparam pc_t S_Q_WAIT1    = 4'd4;
  localparam pc_t S_Q_RD       = 4'd5;
  localparam pc_t S_Q_DIV2     = 4'd6;
  localparam pc_t S_Q_LATCH    = 4'd8;
  localparam pc_t S_TICK_START = 4'd9;
  localparam pc_t S_TICK_STEP  = 4'd10;
  localparam pc_t S_RESULT     = 4'd11;

  // When the condition holds the sequencer jumps to target; otherwise it
  // stays on the step if hold is set, or falls through to the next step.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    pc_t   target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(pc_t pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: S_IDLE};
    case (pc)
      S_IDLE:       w = '{op: OP_ACCEPT,     cond: C_DISPATCH,  hold: 1'b1, target: S_IDLE};
      S_SEED_RD:    w = '{op: OP_SEED_RD,    cond: C_SEED_SKIP, hold: 1'b0, target: S_RESULT};
      S_SEED_WR:    w = '{op: OP_SEED_WR,    cond: C_ALWAYS,    hold: 1'b0, target: S_RESULT};
      S_Q_DIV1:     w = '{op: OP_DIV_WORM,   cond: C_ALWAYS,    hold: 1'b0, target: S_Q_WAIT1};
      S_Q_WAIT1:    w = '{op: OP_NOP,        cond: C_DIV_DONE,  hold: 1'b1, target: S_Q_RD};
      S_Q_RD:       w = '{op: OP_Q_RD,       cond: C_ALWAYS,    hold: 1'b0, target: S_Q_DIV2};
      S_Q_DIV2:     w = '{op: OP_DIV_ROW,    cond: C_ALWAYS,    hold: 1'b0, target: S_Q_LATCH};
      S_Q_LATCH:    w = '{op: OP_Q_LATCH,    cond: C_ALWAYS,    hold: 1'b0, target: S_RESULT};
      S_TICK_START: w = '{op: OP_TICK_START, cond: C_ALWAYS,    hold: 1'b0, target: S_TICK_STEP};
      S_TICK_STEP:  w = '{op: OP_TICK_STEP,  cond: C_PTR_LAST,  hold: 1'b1, target: S_RESULT};
      S_RESULT:     w = '{op: OP_RESULT,     cond: C_OUT_FREE,  hold: 1'b1, target: S_IDLE};
      default:      w = '{op: OP_NOP,        cond: C_ALWAYS,    hold: 1'b0, target: S_IDLE};
    endcase
    return w;
  endfunction

  // Entry step of the routine for each action; the unused code goes
  // straight to the result step with zeros.
  function automatic pc_t dispatch(action_t act);
    pc_t p;
    unique case (act)
      ACT_SEED:  p = S_SEED_RD;
      ACT_TICK:  p = S_TICK_START;
      ACT_QUERY: p = S_Q_DIV1;
      default:   p = S_RESULT;
    endcase
    return p;
  endfunction

  // r mod 3 through a reciprocal: floor(r*171/512) equals floor(r/3) for
  // every byte value.
  function automatic logic [1:0] mod3(logic [RND_W-1:0] r);
    logic [15:0] p;
    logic [6:0]  q;
    logic [7:0]  rem;
    p   = {8'b0, r} * 16'd171;
    q   = p[15:9];
    rem = r - 8'({1'b0, q} * 8'd3);
    return rem[1:0];
  endfunction

endpackage

/* rtl/mwce_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mwce_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 320,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mwce_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// No dependencies; used by the melt wipe column engine for the worm index division.
module mwce_div #(
  parameter int DW = 23,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dsr_r;
  logic [VW:0]   shifted, diff;
  logic          fits;

  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    diff    = shifted - {1'b0, dsr_r};
    fits    = (shifted >= {1'b0, dsr_r});
    rem_nxt = fits ? diff[VW-1:0] : shifted[VW-1:0];
    quo_nxt = {quo_r[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* rtl/melt_wipe_column_engine_unit.sv */
// Top level of the melt wipe column engine: microcoded sequencer, offset RAM
// and serial divider. Depends on mwce_pkg, mwce_ram and mwce_div.
//
// The engine holds one signed drop offset per worm column in a RAM of
// NUM_COLUMNS entries and handles one item at a time; in_ready is high while
// the sequencer waits in its idle step. A seed skips the RAM when its column
// is out of range, a tick streams every RAM entry once through the read and
// write ports, and a query takes the worm index from the bit-serial divider,
// one quotient bit per cycle, while the scaling by LOGICAL_ROWS is a
// reciprocal multiply; the unused action goes straight to the result step.
// The output register lets the next item be accepted while a result still
// waits; a result that finds the register full waits for it to drain. The
// RAM is never cleared: the user must have seeds write every column first;
// the block itself does not enforce this.
module melt_wipe_column_engine_unit #(
  parameter int NUM_COLUMNS  = 320,
  parameter int LOGICAL_ROWS = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mwce_pkg::action_t in_action,
  input  logic [8:0]        in_worm_column,
  input  logic [7:0]        in_random_byte,
  input  logic [11:0]       in_screen_column,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_done_res,
  output mwce_pkg::dim_t    out_start_row,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mwce_pkg::cfg_idx_t cfg_index,
  input  mwce_pkg::dim_t    cfg_data
);

  import mwce_pkg::*;

  localparam int COL_W   = $clog2(NUM_COLUMNS);
  localparam int NUM_W   = $clog2(NUM_COLUMNS + 1);
  localparam int PROD1_W = SX_W + NUM_W;
  localparam int PROD2_W = RND_W + DIM_W;
  localparam int DIV_W   = PROD1_W;

  // Division by LOGICAL_ROWS is a multiply by its rounded-up reciprocal. The
  // rounding error stays below LOGICAL_ROWS, so with a shift of 29 the
  // quotient is exact for every product of PROD2_W bits.
  localparam int ROW_SHIFT = 29;
  localparam int RECIP_W   = ROW_SHIFT + 1;
  localparam logic [RECIP_W-1:0] ROW_RECIP =
    RECIP_W'(((64'd1 << ROW_SHIFT) + 64'(LOGICAL_ROWS) - 64'd1) / 64'(LOGICAL_ROWS));

  // Configuration registers.
  dim_t width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Sequencer.
  pc_t        pc_r, pc_nxt;
  ctrl_word_t cw;
  logic       take, accept, out_free, seed_skip, ptr_last, div_busy;

  logic [COL_W-1:0] ptr_r;
  logic [8:0]       col_r;
  logic [7:0]       rnd_r;
  logic [11:0]      sx_r;
  logic             res_done_r;
  dim_t             res_row_r;
  logic             out_valid_r, out_done_r;
  dim_t             out_row_r;

  assign cw        = ucode(pc_r);
  assign in_ready  = (cw.op == OP_ACCEPT);
  assign accept    = in_ready && in_valid;
  assign out_free  = !out_valid_r || out_ready;
  assign seed_skip = ({23'b0, col_r} >= 32'(NUM_COLUMNS));
  assign ptr_last  = (ptr_r == COL_W'(NUM_COLUMNS - 1));

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:    take = 1'b1;
      C_DISPATCH:  take = accept;
      C_SEED_SKIP: take = seed_skip;
      C_DIV_DONE:  take = !div_busy;
      C_PTR_LAST:  take = ptr_last;
      C_OUT_FREE:  take = out_free;
      default:     take = 1'b1;
    endcase
    if (take) begin
      pc_nxt = (cw.cond == C_DISPATCH) ? dispatch(in_action) : cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Column arithmetic.
  function automatic logic [OFS_W-1:0] seed_value(logic first, logic [7:0] r,
                                                  logic [OFS_W-1:0] prev);
    logic signed [9:0] s;
    logic [1:0]        m;
    m = mod3(r);
    if (first) begin
      s = 10'sd0 - $signed({6'b0, r[3:0]});
    end else begin
      s = $signed({prev[8], prev}) + $signed({8'b0, m}) - 10'sd1;
      if (s < -10'sd15) begin
        s = -10'sd15;
      end else if (s > 10'sd0) begin
        s = 10'sd0;
      end
    end
    return s[OFS_W-1:0];
  endfunction

  function automatic logic [OFS_W-1:0] tick_value(logic [OFS_W-1:0] v);
    logic signed [9:0] v10, lr, dy, s;
    v10 = $signed({v[8], v});
    lr  = $signed(10'(LOGICAL_ROWS));
    s   = v10;
    if (v10 < 10'sd0) begin
      s = v10 + 10'sd1;
    end else if (v10 < lr) begin
      dy = (v10 < 10'sd16) ? v10 + 10'sd1 : 10'sd8;
      s  = v10 + dy;
      if (s >= lr) begin
        s = lr;
      end
    end
    return s[OFS_W-1:0];
  endfunction

  // Datapath.
  logic                       ram_we, ram_re;
  logic [COL_W-1:0]           ram_waddr, ram_raddr;
  logic [OFS_W-1:0]           ram_wdata, ram_rdata;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend, div_quot;
  dim_t                       div_divisor;
  logic [COL_W-1:0]           worm_sat;
  logic [7:0]                 vpos;
  logic                       at_floor;
  logic [PROD2_W-1:0]         prod_r;
  logic [PROD2_W+RECIP_W-1:0] row_full;

  assign worm_sat = (div_quot >= DIV_W'(NUM_COLUMNS)) ? COL_W'(NUM_COLUMNS - 1)
                                                      : COL_W'(div_quot);
  assign vpos     = ram_rdata[8] ? 8'd0 : ram_rdata[7:0];
  assign at_floor = ($signed({ram_rdata[8], ram_rdata}) >= $signed(10'(LOGICAL_ROWS)));
  assign row_full = {{RECIP_W{1'b0}}, prod_r} * {{PROD2_W{1'b0}}, ROW_RECIP};

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (cw.op)
      OP_SEED_RD: begin
        ram_re    = 1'b1;
        ram_raddr = (col_r == 9'd0) ? '0 : COL_W'(col_r - 9'd1);
      end
      OP_SEED_WR: begin
        ram_we    = 1'b1;
        ram_waddr = COL_W'(col_r);
        ram_wdata = seed_value(col_r == 9'd0, rnd_r, ram_rdata);
      end
      OP_DIV_WORM: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sx_r) * DIV_W'(NUM_COLUMNS);
        div_divisor  = (width_r == '0) ? DIM_W'(1) : width_r;
      end
      OP_Q_RD: begin
        ram_re    = 1'b1;
        ram_raddr = worm_sat;
      end
      OP_TICK_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      OP_TICK_STEP: begin
        // Entry ptr is updated while the next one is read.
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = tick_value(ram_rdata);
        ram_re    = !ptr_last;
        ram_raddr = ptr_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= in_worm_column;
      rnd_r <= in_random_byte;
      sx_r  <= in_screen_column;
    end
    if (cw.op == OP_TICK_START) begin
      ptr_r <= '0;
    end else if (cw.op == OP_TICK_STEP) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (cw.op == OP_DIV_ROW) begin
      prod_r <= PROD2_W'(vpos) * PROD2_W'(height_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_done_r <= 1'b0;
      res_row_r  <= '0;
    end else begin
      if (accept) begin
        res_done_r <= 1'b0;
        res_row_r  <= '0;
      end
      if (cw.op == OP_TICK_START) begin
        res_done_r <= 1'b1;
      end else if (cw.op == OP_TICK_STEP) begin
        res_done_r <= res_done_r & at_floor;
      end
      if (cw.op == OP_Q_LATCH) begin
        res_row_r <= row_full[ROW_SHIFT +: DIM_W];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cw.op == OP_RESULT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.op == OP_RESULT) && out_free) begin
      out_done_r <= res_done_r;
      out_row_r  <= res_row_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_done_res  = out_done_r;
  assign out_start_row = out_row_r;

  mwce_ram #(
    .WIDTH(OFS_W),
    .DEPTH(NUM_COLUMNS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mwce_div #(
    .DW(DIV_W),
    .VW(DIM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(div_quot)
  );

endmodule

/* rtl/mwce_check.sv */
// Port-level checker for the melt wipe column engine, bound to the top level.
// Depends on mwce_pkg for the port types.
module mwce_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_done_res,
  input mwce_pkg::dim_t     out_start_row
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_done_res) && $stable(out_start_row))
    else $error("stalled result changed");

  // One item at a time: the engine is busy right after taking an item.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one under way");

  // A result comes from either a tick or a query, never from both.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && (out_start_row != '0)))
    else $error("done flag and start row both set");

endmodule

bind melt_wipe_column_engine_unit mwce_check u_check (.*);
